// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is asserted.
`define SVRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// File: hdl/svrr_pkg.sv
// ----------------------------------------------------------------------------
// svrr_pkg
// Shared types, widths and codes of the rotated rectangle line-of-sight block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svrr_pkg;

  localparam int MAX_OBSTACLES = 64;
  localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
  localparam int IDX_W         = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int OUT_CNT_W     = 7;

  // Datapath widths of the shared multiplier, its accumulator, the stored products and corners.
  localparam int CHUNK_W = 14;
  localparam int OP_W    = 4 * CHUNK_W;
  localparam int ACC_W   = 108;
  localparam int PW      = 52;
  localparam int VW      = 54;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         index;
    logic signed [31:0] coord_a_x;
    logic signed [31:0] coord_a_y;
    logic signed [31:0] coord_b_x;
    logic signed [31:0] coord_b_y;
    logic signed [15:0] angle_cos;
    logic signed [15:0] angle_sin;
    logic               flag_a;
    logic               flag_b;
    logic [30:0]        expand;
  } svrr_in_t;

  typedef struct packed {
    logic                 clear;
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] obstacle_count;
  } svrr_out_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic               mov;
    logic               inf;
  } svrr_entry_t;

  // Where a finished multiply-accumulate result goes.
  typedef enum logic [3:0] {
    D_LXA, D_LYA, D_LXB, D_LYB,
    D_P1, D_P2, D_P3, D_P4,
    D_DEN, D_TN, D_UN
  } svrr_dest_t;

  typedef struct packed {
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
    logic                   long_b;
    logic                   sub;
    logic                   first;
    logic                   last;
    svrr_dest_t             dest;
  } svrr_mac_cmd_t;

  typedef struct packed {
    logic                    vld;
    svrr_dest_t              dest;
    logic signed [ACC_W-1:0] value;
  } svrr_mac_res_t;

endpackage

`default_nettype wire

// File: hdl/svrr_mac.sv
// ----------------------------------------------------------------------------
// svrr_mac
// Chunked signed multiply-accumulate unit, one 14-bit slice of b per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svrr_mac import svrr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  svrr_mac_cmd_t cmd,
  output logic          cmd_ready,
  output svrr_mac_res_t res,
  output logic          idle
);

  logic                          busy_r;
  svrr_mac_cmd_t                 cmd_r;
  logic [1:0]                    j_r;
  logic [1:0]                    last_j;
  logic                          fin_j;
  logic [CHUNK_W-1:0]            craw;
  logic signed [CHUNK_W:0]       chunk;

  logic                          p_vld_r;
  logic signed [OP_W+CHUNK_W:0]  prod_r;
  logic [1:0]                    p_j_r;
  logic                          p_sub_r;
  logic                          p_first_r;
  logic                          p_fin_r;
  svrr_dest_t                    p_dest_r;

  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_base;
  logic signed [ACC_W-1:0]       pext;
  logic signed [ACC_W-1:0]       psh;
  logic signed [ACC_W-1:0]       acc_nxt;

  logic                          res_vld_r;
  svrr_dest_t                    res_dest_r;
  logic signed [ACC_W-1:0]       res_value_r;

  assign last_j    = cmd_r.long_b ? 2'd3 : 2'd1;
  assign fin_j     = busy_r && (j_r == last_j);
  assign cmd_ready = !busy_r || fin_j;

  // Lower slices are unsigned, the top slice carries the sign of b.
  always_comb begin
    craw  = cmd_r.b[j_r * CHUNK_W +: CHUNK_W];
    chunk = (j_r == last_j) ? {craw[CHUNK_W-1], craw} : {1'b0, craw};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      busy_r <= 1'b1;
    end else if (fin_j) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
      j_r   <= 2'd0;
    end else if (busy_r) begin
      j_r <= j_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= $signed(cmd_r.a) * chunk;
    p_j_r     <= j_r;
    p_sub_r   <= cmd_r.sub;
    p_first_r <= cmd_r.first && (j_r == 2'd0);
    p_fin_r   <= cmd_r.last && fin_j;
    p_dest_r  <= cmd_r.dest;
  end

  always_comb begin
    pext     = ACC_W'(prod_r);
    psh      = pext <<< (CHUNK_W * p_j_r);
    acc_base = p_first_r ? {ACC_W{1'b0}} : acc_r;
    acc_nxt  = p_sub_r ? (acc_base - psh) : (acc_base + psh);
  end

  always_ff @(posedge clk) begin
    if (p_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (p_vld_r && p_fin_r) begin
      res_value_r <= acc_nxt;
      res_dest_r  <= p_dest_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= p_vld_r && p_fin_r;
    end
  end

  assign res  = '{vld: res_vld_r, dest: res_dest_r, value: res_value_r};
  assign idle = !busy_r && !p_vld_r && !res_vld_r;

endmodule

`default_nettype wire

// File: hdl/segment_vs_rotated_rect_los.sv
// One request at a time: an append writes the table on acceptance, a remove shifts
//   the later entries down one by one (or ends without shifting when the index is out
//   of range), and a query walks the entries, skipping the ineligible ones.
// Queries share one chunked multiplier: two 14-bit slices of b per cosine/sine
//   product and four per cross-product term.
// Reset clears the entry count, the sequencer and the output valid flag, not the table.
// ----------------------------------------------------------------------------
// segment_vs_rotated_rect_los
// Obstacle table of rotated rectangles with append, remove and line-of-sight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_vs_rotated_rect_los import svrr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  svrr_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output svrr_out_t out_data
);

  localparam int RW = (CNT_W > 6) ? CNT_W : 6;
  localparam logic [3:0] PSTEP_LAST = 4'd11;
  localparam logic [3:0] ESTEP_LAST = 4'd5;

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_LD    = 11'b00000000100,
    S_PMUL  = 11'b00000001000,
    S_PCHK  = 11'b00000010000,
    S_EPREP = 11'b00000100000,
    S_EMUL  = 11'b00001000000,
    S_ECHK  = 11'b00010000000,
    S_SHRD  = 11'b00100000000,
    S_SHWR  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state_r;

  // Entry count and the walk index used by queries and removes.
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] i1;
  logic [3:0]       s_r;
  logic [1:0]       k_r;

  // Query operands captured when the request word is accepted.
  logic signed [31:0] q_ax_r, q_ay_r, q_bx_r, q_by_r;
  logic               q_fa_r, q_fb_r;
  logic [30:0]        q_grow_r;
  logic signed [47:0] rx_r, ry_r;

  logic       res_clear_r;
  logic [1:0] res_status_r;

  logic      out_valid_r;
  svrr_out_t out_data_r;

  // The obstacle table: one synchronous memory, one write and one read port.
  logic [$bits(svrr_entry_t)-1:0] mem [MAX_OBSTACLES];
  logic [$bits(svrr_entry_t)-1:0] rd_data_r;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_waddr;
  logic [$bits(svrr_entry_t)-1:0] mem_wdata;
  logic                           mem_re;
  logic [IDX_W-1:0]               mem_raddr;

  svrr_entry_t ent;
  svrr_entry_t in_ent;

  // Per-entry terms derived once the entry has been read.
  logic signed [33:0] c2x, c2y;
  logic signed [34:0] dxa_r, dya_r, dxb_r, dyb_r;
  logic signed [46:0] hx_r, hy_r, nhx_r, nhy_r;
  logic signed [47:0] cx_r, cy_r;
  logic signed [33:0] ex_r, ey_r;

  // Products returned by the multiplier.
  logic signed [PW-1:0]    lxa_r, lya_r, lxb_r, lyb_r;
  logic signed [PW-1:0]    p1_r, p2_r, p3_r, p4_r;
  logic signed [ACC_W-1:0] den_r, tn_r, un_r;

  // Corners of the grown rectangle; the edge under test runs from 0 to 1.
  logic signed [VW-1:0]   vx_r [4];
  logic signed [VW-1:0]   vy_r [4];
  logic signed [OP_W-1:0] dxe_r, dye_r, wxe_r, wye_r;

  logic          acc_in;
  logic          is_elig;
  logic          ins_a, ins_b;
  logic          den_zero, den_neg, hit;
  logic [RW-1:0] idx_ext, cnt_ext;

  logic          mac_valid;
  svrr_mac_cmd_t mac_cmd;
  logic          mac_ready;
  svrr_mac_res_t mac_res;
  logic          mac_idle;

  function automatic svrr_mac_cmd_t mk(input logic signed [OP_W-1:0] a,
                                       input logic signed [OP_W-1:0] b,
                                       input logic lng, input logic sb,
                                       input logic fst, input logic lst,
                                       input svrr_dest_t d);
    svrr_mac_cmd_t c;
    c = '{a: a, b: b, long_b: lng, sub: sb, first: fst, last: lst, dest: d};
    return c;
  endfunction

  assign acc_in   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign ent      = svrr_entry_t'(rd_data_r);
  assign i1       = i_r + CNT_W'(1);
  assign idx_ext  = RW'(in_data.index);
  assign cnt_ext  = RW'(cnt_r);

  assign in_ent = '{px: in_data.coord_a_x, py: in_data.coord_a_y,
                    sx: in_data.coord_b_x, sy: in_data.coord_b_y,
                    cs: in_data.angle_cos, sn: in_data.angle_sin,
                    mov: in_data.flag_a, inf: in_data.flag_b};

  // Doubled center of the stored rectangle, straight from the read data.
  assign c2x = (34'(ent.px) <<< 1) + 34'(ent.sx);
  assign c2y = (34'(ent.py) <<< 1) + 34'(ent.sy);

  assign is_elig = (q_fa_r && ent.mov) || (q_fb_r && ent.inf);

  // A point is inside when both rotated offsets sit within the half extents.
  assign ins_a = (lxa_r >= nhx_r) && (lxa_r <= hx_r) && (lya_r >= nhy_r) && (lya_r <= hy_r);
  assign ins_b = (lxb_r >= nhx_r) && (lxb_r <= hx_r) && (lyb_r >= nhy_r) && (lyb_r <= hy_r);

  // Both parameters of the crossing must lie between zero and the
  // denominator, on whichever side of zero the denominator falls.
  always_comb begin
    den_zero = (den_r == {ACC_W{1'b0}});
    den_neg  = den_r[ACC_W-1];
    if (den_neg) begin
      hit = (tn_r[ACC_W-1] || (tn_r == {ACC_W{1'b0}})) && (tn_r >= den_r) &&
            (un_r[ACC_W-1] || (un_r == {ACC_W{1'b0}})) && (un_r >= den_r);
    end else begin
      hit = !tn_r[ACC_W-1] && (tn_r <= den_r) && !un_r[ACC_W-1] && (un_r <= den_r);
    end
    hit = hit && !den_zero;
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[IDX_W-1:0];
    mem_wdata = in_ent;
    mem_re    = 1'b0;
    mem_raddr = i_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (acc_in && (in_data.req_type == REQ_APPEND) &&
            (cnt_r < CNT_W'(MAX_OBSTACLES))) begin
          mem_we = 1'b1;
        end
      end
      S_RD: begin
        mem_re = (i_r < cnt_r);
      end
      S_SHRD: begin
        mem_re    = (i1 < cnt_r);
        mem_raddr = i1[IDX_W-1:0];
      end
      S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[IDX_W-1:0];
        mem_wdata = rd_data_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Multiplier program. The first twelve steps rotate both endpoints into the
  // rectangle's frame and form the four corner products; the next six steps,
  // run once per edge, form the denominator and the two crossing numerators.
  always_comb begin
    mac_valid = 1'b0;
    mac_cmd   = mk(OP_W'(dxa_r), OP_W'(ent.cs), 1'b0, 1'b0, 1'b1, 1'b0, D_LXA);
    if (state_r == S_PMUL) begin
      mac_valid = 1'b1;
      case (s_r)
        4'd0:  mac_cmd = mk(OP_W'(dxa_r), OP_W'(ent.cs), 1'b0, 1'b0, 1'b1, 1'b0, D_LXA);
        4'd1:  mac_cmd = mk(OP_W'(dya_r), OP_W'(ent.sn), 1'b0, 1'b0, 1'b0, 1'b1, D_LXA);
        4'd2:  mac_cmd = mk(OP_W'(dya_r), OP_W'(ent.cs), 1'b0, 1'b0, 1'b1, 1'b0, D_LYA);
        4'd3:  mac_cmd = mk(OP_W'(dxa_r), OP_W'(ent.sn), 1'b0, 1'b1, 1'b0, 1'b1, D_LYA);
        4'd4:  mac_cmd = mk(OP_W'(dxb_r), OP_W'(ent.cs), 1'b0, 1'b0, 1'b1, 1'b0, D_LXB);
        4'd5:  mac_cmd = mk(OP_W'(dyb_r), OP_W'(ent.sn), 1'b0, 1'b0, 1'b0, 1'b1, D_LXB);
        4'd6:  mac_cmd = mk(OP_W'(dyb_r), OP_W'(ent.cs), 1'b0, 1'b0, 1'b1, 1'b0, D_LYB);
        4'd7:  mac_cmd = mk(OP_W'(dxb_r), OP_W'(ent.sn), 1'b0, 1'b1, 1'b0, 1'b1, D_LYB);
        4'd8:  mac_cmd = mk(OP_W'(ex_r), OP_W'(ent.cs), 1'b0, 1'b0, 1'b1, 1'b1, D_P1);
        4'd9:  mac_cmd = mk(OP_W'(ey_r), OP_W'(ent.sn), 1'b0, 1'b0, 1'b1, 1'b1, D_P2);
        4'd10: mac_cmd = mk(OP_W'(ex_r), OP_W'(ent.sn), 1'b0, 1'b0, 1'b1, 1'b1, D_P3);
        default: mac_cmd = mk(OP_W'(ey_r), OP_W'(ent.cs), 1'b0, 1'b0, 1'b1, 1'b1, D_P4);
      endcase
    end else if (state_r == S_EMUL) begin
      mac_valid = 1'b1;
      case (s_r)
        4'd0: mac_cmd = mk(OP_W'(rx_r), dye_r, 1'b1, 1'b0, 1'b1, 1'b0, D_DEN);
        4'd1: mac_cmd = mk(OP_W'(ry_r), dxe_r, 1'b1, 1'b1, 1'b0, 1'b1, D_DEN);
        4'd2: mac_cmd = mk(wxe_r, dye_r, 1'b1, 1'b0, 1'b1, 1'b0, D_TN);
        4'd3: mac_cmd = mk(wye_r, dxe_r, 1'b1, 1'b1, 1'b0, 1'b1, D_TN);
        4'd4: mac_cmd = mk(wxe_r, OP_W'(ry_r), 1'b1, 1'b0, 1'b1, 1'b0, D_UN);
        default: mac_cmd = mk(wye_r, OP_W'(rx_r), 1'b1, 1'b1, 1'b0, 1'b1, D_UN);
      endcase
    end
  end

  svrr_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (mac_valid),
    .cmd       (mac_cmd),
    .cmd_ready (mac_ready),
    .res       (mac_res),
    .idle      (mac_idle)
  );

  // Finished products land in their named registers.
  always_ff @(posedge clk) begin
    if (mac_res.vld) begin
      case (mac_res.dest)
        D_LXA:   lxa_r <= PW'(mac_res.value);
        D_LYA:   lya_r <= PW'(mac_res.value);
        D_LXB:   lxb_r <= PW'(mac_res.value);
        D_LYB:   lyb_r <= PW'(mac_res.value);
        D_P1:    p1_r  <= PW'(mac_res.value);
        D_P2:    p2_r  <= PW'(mac_res.value);
        D_P3:    p3_r  <= PW'(mac_res.value);
        D_P4:    p4_r  <= PW'(mac_res.value);
        D_DEN:   den_r <= mac_res.value;
        D_TN:    tn_r  <= mac_res.value;
        D_UN:    un_r  <= mac_res.value;
        default: begin
        end
      endcase
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            case (in_data.req_type)
              REQ_APPEND: begin
                if (cnt_r < CNT_W'(MAX_OBSTACLES)) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end
                state_r <= S_DONE;
              end
              REQ_REMOVE: begin
                state_r <= (idx_ext < cnt_ext) ? S_SHRD : S_DONE;
              end
              REQ_QUERY: begin
                state_r <= S_RD;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= (i_r < cnt_r) ? S_LD : S_DONE;
        end
        S_LD: begin
          state_r <= is_elig ? S_PMUL : S_RD;
        end
        S_PMUL: begin
          if (mac_ready && (s_r == PSTEP_LAST)) begin
            state_r <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (mac_idle) begin
            state_r <= (ins_a || ins_b) ? S_DONE : S_EPREP;
          end
        end
        S_EPREP: begin
          state_r <= S_EMUL;
        end
        S_EMUL: begin
          if (mac_ready && (s_r == ESTEP_LAST)) begin
            state_r <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (mac_idle) begin
            if (hit) begin
              state_r <= S_DONE;
            end else if (k_r == 2'd3) begin
              state_r <= S_RD;
            end else begin
              state_r <= S_EPREP;
            end
          end
        end
        S_SHRD: begin
          if (i1 < cnt_r) begin
            state_r <= S_SHWR;
          end else begin
            cnt_r   <= cnt_r - CNT_W'(1);
            state_r <= S_DONE;
          end
        end
        S_SHWR: begin
          state_r <= S_SHRD;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Sequencer datapath: counters, captured operands and derived terms.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          q_ax_r   <= in_data.coord_a_x;
          q_ay_r   <= in_data.coord_a_y;
          q_bx_r   <= in_data.coord_b_x;
          q_by_r   <= in_data.coord_b_y;
          q_fa_r   <= in_data.flag_a;
          q_fb_r   <= in_data.flag_b;
          q_grow_r <= in_data.expand;
          rx_r     <= (48'(in_data.coord_b_x) - 48'(in_data.coord_a_x)) <<< 15;
          ry_r     <= (48'(in_data.coord_b_y) - 48'(in_data.coord_a_y)) <<< 15;
          i_r      <= '0;
          res_clear_r  <= (in_data.req_type == REQ_QUERY);
          res_status_r <= ST_OK;
          case (in_data.req_type)
            REQ_APPEND: begin
              if (!(cnt_r < CNT_W'(MAX_OBSTACLES))) begin
                res_status_r <= ST_FULL;
              end
            end
            REQ_REMOVE: begin
              if (idx_ext < cnt_ext) begin
                i_r <= CNT_W'(in_data.index);
              end else begin
                res_status_r <= ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LD: begin
        dxa_r <= (35'(q_ax_r) <<< 1) - 35'(c2x);
        dya_r <= (35'(q_ay_r) <<< 1) - 35'(c2y);
        dxb_r <= (35'(q_bx_r) <<< 1) - 35'(c2x);
        dyb_r <= (35'(q_by_r) <<< 1) - 35'(c2y);
        hx_r  <= 47'(ent.sx) <<< 14;
        hy_r  <= 47'(ent.sy) <<< 14;
        nhx_r <= -(47'(ent.sx) <<< 14);
        nhy_r <= -(47'(ent.sy) <<< 14);
        cx_r  <= 48'(c2x) <<< 14;
        cy_r  <= 48'(c2y) <<< 14;
        ex_r  <= 34'(ent.sx) + $signed({2'b00, q_grow_r, 1'b0});
        ey_r  <= 34'(ent.sy) + $signed({2'b00, q_grow_r, 1'b0});
        s_r   <= 4'd0;
        if (!is_elig) begin
          i_r <= i1;
        end
      end
      S_PMUL: begin
        if (mac_ready) begin
          s_r <= s_r + 4'd1;
        end
      end
      S_PCHK: begin
        if (mac_idle) begin
          if (ins_a || ins_b) begin
            res_clear_r <= 1'b0;
          end
          // Corners in order (-,-), (+,-), (+,+), (-,+) of the grown extents.
          vx_r[0] <= VW'(cx_r) - VW'(p1_r) + VW'(p2_r);
          vy_r[0] <= VW'(cy_r) - VW'(p3_r) - VW'(p4_r);
          vx_r[1] <= VW'(cx_r) + VW'(p1_r) + VW'(p2_r);
          vy_r[1] <= VW'(cy_r) + VW'(p3_r) - VW'(p4_r);
          vx_r[2] <= VW'(cx_r) + VW'(p1_r) - VW'(p2_r);
          vy_r[2] <= VW'(cy_r) + VW'(p3_r) + VW'(p4_r);
          vx_r[3] <= VW'(cx_r) - VW'(p1_r) - VW'(p2_r);
          vy_r[3] <= VW'(cy_r) - VW'(p3_r) + VW'(p4_r);
          k_r     <= 2'd0;
        end
      end
      S_EPREP: begin
        dxe_r <= OP_W'(vx_r[1]) - OP_W'(vx_r[0]);
        dye_r <= OP_W'(vy_r[1]) - OP_W'(vy_r[0]);
        wxe_r <= OP_W'(vx_r[0]) - (OP_W'(q_ax_r) <<< 15);
        wye_r <= OP_W'(vy_r[0]) - (OP_W'(q_ay_r) <<< 15);
        s_r   <= 4'd0;
      end
      S_EMUL: begin
        if (mac_ready) begin
          s_r <= s_r + 4'd1;
        end
      end
      S_ECHK: begin
        if (mac_idle) begin
          if (hit) begin
            res_clear_r <= 1'b0;
          end else if (k_r == 2'd3) begin
            i_r <= i1;
          end else begin
            // Rotate the corners so the next edge again runs from 0 to 1.
            k_r     <= k_r + 2'd1;
            vx_r[0] <= vx_r[1];
            vx_r[1] <= vx_r[2];
            vx_r[2] <= vx_r[3];
            vx_r[3] <= vx_r[0];
            vy_r[0] <= vy_r[1];
            vy_r[1] <= vy_r[2];
            vy_r[2] <= vy_r[3];
            vy_r[3] <= vy_r[0];
          end
        end
      end
      S_SHWR: begin
        i_r <= i1;
      end
      default: begin
      end
    endcase
  end

  // Output register: the next request is taken while a result still waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_data_r <= '{clear: res_clear_r, status: res_status_r,
                      obstacle_count: OUT_CNT_W'(cnt_r)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/svrr_checker.sv
// ----------------------------------------------------------------------------
// svrr_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module svrr_checker import svrr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire svrr_out_t out_data
);

  `SVRR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SVRR_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  `SVRR_ASSERT_IMP(a_full_count, out_valid && (out_data.status == ST_FULL), out_data.obstacle_count == OUT_CNT_W'(MAX_OBSTACLES))
  `SVRR_ASSERT_IMP(a_clear_ok, out_valid && out_data.clear, out_data.status == ST_OK)

endmodule

bind segment_vs_rotated_rect_los svrr_checker u_svrr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
